/* rtl/interval_arithmetic_unit_defines.svh */
// assertion macros for the interval arithmetic unit
`ifndef INTERVAL_ARITHMETIC_UNIT_DEFINES_SVH
`define INTERVAL_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define IAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/iau_pkg.sv */
// ----------------------------------------------------------------------------
// iau_pkg
// Types and constants shared by the interval arithmetic unit.
// ----------------------------------------------------------------------------
package iau_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH);

  localparam logic [VALUE_WIDTH-1:0] VAL_MIN  = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH-1:0] VAL_ONES = {VALUE_WIDTH{1'b1}};
  localparam logic [VALUE_WIDTH-1:0] VAL_ZERO = '0;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_SDIV = 3'd3,
    OP_UDIV = 3'd4,
    OP_JOIN = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    KIND_UNKNOWN   = 2'd0,
    KIND_BOUNDED   = 2'd1,
    KIND_UNBOUNDED = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CLS_DIRECT = 2'd0,
    CLS_MUL    = 2'd1,
    CLS_SDIV   = 2'd2,
    CLS_UDIV   = 2'd3
  } cls_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MUL_TAIL,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DIV_FIN,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    kind_t                  kind;
    logic [VALUE_WIDTH-1:0] lo;
    logic [VALUE_WIDTH-1:0] hi;
  } res_t;

  typedef struct packed {
    cls_t                   cls;
    res_t                   res;
    logic [VALUE_WIDTH-1:0] la;
    logic [VALUE_WIDTH-1:0] ha;
    logic [VALUE_WIDTH-1:0] lb;
    logic [VALUE_WIDTH-1:0] hb;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* rtl/iau_queue.sv */
// ----------------------------------------------------------------------------
// iau_queue
// Small first-in first-out queue of commands built from registers.
// ----------------------------------------------------------------------------
`include "interval_arithmetic_unit_defines.svh"

module iau_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  iau_pkg::cmd_t    wdata,
  input  logic             pop,
  output iau_pkg::cmd_t    rdata,
  output iau_pkg::q_status_t status
);
  import iau_pkg::*;

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `IAU_ASSERT_NOW(a_count_bound, 1'b1, count <= (QPTR_W+1)'(QUEUE_DEPTH), "queue count over depth")
  `IAU_ASSERT_NEXT(a_count_up, do_push && !do_pop, count == $past(count) + 1'b1, "count not raised")
  `IAU_ASSERT_NEXT(a_count_down, do_pop && !do_push, count == $past(count) - 1'b1, "count not lowered")

endmodule

/* rtl/iau_front.sv */
// ----------------------------------------------------------------------------
// iau_front
// Classifies an item: resolves add, sub, join and trivial cases at once and
// passes multiply and divide on with their operands.
// ----------------------------------------------------------------------------
module iau_front (
  input  logic [2:0]                          operation,
  input  logic [1:0]                          kind_a,
  input  logic [iau_pkg::VALUE_WIDTH-1:0]     low_a,
  input  logic [iau_pkg::VALUE_WIDTH-1:0]     high_a,
  input  logic [1:0]                          kind_b,
  input  logic [iau_pkg::VALUE_WIDTH-1:0]     low_b,
  input  logic [iau_pkg::VALUE_WIDTH-1:0]     high_b,
  output iau_pkg::cmd_t                       cmd
);
  import iau_pkg::*;

  localparam int W = VALUE_WIDTH;

  kind_t         ka;
  kind_t         kb;
  logic [W-1:0]  sum_lo;
  logic [W-1:0]  sum_hi;
  logic [W-1:0]  dif_lo;
  logic [W-1:0]  dif_hi;
  logic          add_ovf;
  logic          sub_ovf;
  logic [W-1:0]  mag_la;
  logic [W-1:0]  mag_ha;
  logic [W-1:0]  mag_m;
  logic          spans_zero;
  logic          sdiv_bad;
  res_t          unb;
  res_t          unk;

  function automatic kind_t norm_kind(input logic [1:0] k);
    kind_t r;
    case (k)
      2'd0:    r = KIND_UNKNOWN;
      2'd1:    r = KIND_BOUNDED;
      default: r = KIND_UNBOUNDED;
    endcase
    return r;
  endfunction

  always_comb begin
    ka = norm_kind(kind_a);
    kb = norm_kind(kind_b);
    unb = '{kind: KIND_UNBOUNDED, lo: VAL_ZERO, hi: VAL_ZERO};
    unk = '{kind: KIND_UNKNOWN, lo: VAL_ZERO, hi: VAL_ZERO};

    sum_lo = low_a + low_b;
    sum_hi = high_a + high_b;
    dif_lo = low_a - high_b;
    dif_hi = high_a - low_b;
    add_ovf = ((low_a[W-1] == low_b[W-1]) && (sum_lo[W-1] != low_a[W-1])) ||
              ((high_a[W-1] == high_b[W-1]) && (sum_hi[W-1] != high_a[W-1]));
    sub_ovf = ((low_a[W-1] != high_b[W-1]) && (dif_lo[W-1] != low_a[W-1])) ||
              ((high_a[W-1] != low_b[W-1]) && (dif_hi[W-1] != high_a[W-1]));

    mag_la = low_a[W-1] ? (VAL_ZERO - low_a) : low_a;
    mag_ha = high_a[W-1] ? (VAL_ZERO - high_a) : high_a;
    mag_m  = (mag_la > mag_ha) ? mag_la : mag_ha;
    spans_zero = low_b[W-1] && !high_b[W-1] && (high_b != VAL_ZERO);
    // zero divisor bound, or most negative over minus one
    sdiv_bad = (low_b == VAL_ZERO) || (high_b == VAL_ZERO) ||
               (((low_a == VAL_MIN) || (high_a == VAL_MIN)) &&
                ((low_b == VAL_ONES) || (high_b == VAL_ONES)));

    cmd.cls = CLS_DIRECT;
    cmd.res = unb;
    cmd.la  = low_a;
    cmd.ha  = high_a;
    cmd.lb  = low_b;
    cmd.hb  = high_b;

    if (operation == OP_JOIN) begin
      if (ka == KIND_UNKNOWN) begin
        cmd.res.kind = kb;
        if (kb == KIND_BOUNDED) begin
          cmd.res.lo = low_b;
          cmd.res.hi = high_b;
        end
      end else if (kb == KIND_UNKNOWN) begin
        cmd.res.kind = ka;
        if (ka == KIND_BOUNDED) begin
          cmd.res.lo = low_a;
          cmd.res.hi = high_a;
        end
      end else if (ka == KIND_UNBOUNDED || kb == KIND_UNBOUNDED) begin
        cmd.res = unb;
      end else begin
        cmd.res.kind = KIND_BOUNDED;
        cmd.res.lo = ($signed(low_a) < $signed(low_b)) ? low_a : low_b;
        cmd.res.hi = ($signed(high_b) < $signed(high_a)) ? high_a : high_b;
      end
    end else if (ka != KIND_BOUNDED || kb != KIND_BOUNDED) begin
      cmd.res = (ka == KIND_UNBOUNDED || kb == KIND_UNBOUNDED) ? unb : unk;
    end else begin
      case (operation)
        OP_ADD: begin
          if (!add_ovf) begin
            cmd.res = '{kind: KIND_BOUNDED, lo: sum_lo, hi: sum_hi};
          end
        end
        OP_SUB: begin
          if (!sub_ovf) begin
            cmd.res = '{kind: KIND_BOUNDED, lo: dif_lo, hi: dif_hi};
          end
        end
        OP_MUL: begin
          cmd.cls = CLS_MUL;
        end
        OP_SDIV: begin
          if (spans_zero) begin
            if (low_a != VAL_MIN && high_a != VAL_MIN) begin
              cmd.res = '{kind: KIND_BOUNDED, lo: VAL_ZERO - mag_m, hi: mag_m};
            end
          end else if (!sdiv_bad) begin
            cmd.cls = CLS_SDIV;
          end
        end
        OP_UDIV: begin
          if (low_b != VAL_ZERO && high_b != VAL_ZERO) begin
            cmd.cls = CLS_UDIV;
          end
        end
        default: begin
          cmd.res = unb;
        end
      endcase
    end
  end

endmodule

/* rtl/iau_back.sv */
// ----------------------------------------------------------------------------
// iau_back
// Executes queued commands: passes resolved results through, runs the four
// corner products on one multiplier and corner quotients on one radix-2
// divider, and forms the hull.
// ----------------------------------------------------------------------------
module iau_back (
  input  logic                clk,
  input  logic                rst,
  input  iau_pkg::cmd_t       cmd,
  input  iau_pkg::q_status_t  cmd_status,
  output logic                cmd_pop,
  input  iau_pkg::q_status_t  res_status,
  output logic                res_push,
  output iau_pkg::cmd_t       res_cmd
);
  import iau_pkg::*;

  localparam int W = VALUE_WIDTH;

  back_state_t          state;
  back_state_t          state_next;
  logic [1:0]           idx;
  logic [W-1:0]         a_sel;
  logic [W-1:0]         b_sel;
  logic signed [2*W-1:0] prod;
  logic                 pval;
  logic [1:0]           pidx;
  logic                 ovf;
  logic [W-1:0]         acc_lo;
  logic [W-1:0]         acc_hi;
  logic [W-1:0]         dvd;
  logic [W-1:0]         dvs;
  logic [W-1:0]         rem;
  logic [W:0]           rem_sh;
  logic [W:0]           trial;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 qneg;
  logic [W-1:0]         quot;
  logic [W-1:0]         pv;
  logic                 pfits;
  logic                 last_div;
  logic                 is_udiv;

  assign is_udiv  = (cmd.cls == CLS_UDIV);
  assign last_div = is_udiv ? (idx == 2'd1) : (idx == 2'd3);

  // corner operands; unsigned divide takes low_a/high_b then high_a/low_b
  always_comb begin
    if (is_udiv) begin
      a_sel = idx[0] ? cmd.ha : cmd.la;
      b_sel = idx[0] ? cmd.lb : cmd.hb;
    end else begin
      a_sel = idx[1] ? cmd.ha : cmd.la;
      b_sel = idx[0] ? cmd.hb : cmd.lb;
    end
  end

  assign rem_sh = {rem, dvd[W-1]};
  assign trial  = rem_sh - {1'b0, dvs};
  assign quot   = qneg ? (VAL_ZERO - dvd) : dvd;
  assign pv     = prod[W-1:0];
  // product fits when its upper half is a sign extension
  assign pfits  = (prod[2*W-1:W-1] == '0) || (prod[2*W-1:W-1] == '1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!cmd_status.empty) begin
          case (cmd.cls)
            CLS_MUL:  state_next = ST_MUL;
            CLS_SDIV: state_next = ST_DIV_LOAD;
            CLS_UDIV: state_next = ST_DIV_LOAD;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_MUL:      state_next = (idx == 2'd3) ? ST_MUL_TAIL : ST_MUL;
      ST_MUL_TAIL: state_next = ST_DONE;
      ST_DIV_LOAD: state_next = ST_DIV_RUN;
      ST_DIV_RUN:  state_next = (cnt == DIV_CNT_W'(W-1)) ? ST_DIV_FIN : ST_DIV_RUN;
      ST_DIV_FIN:  state_next = last_div ? ST_DONE : ST_DIV_LOAD;
      ST_DONE:     state_next = res_status.full ? ST_DONE : ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    res_cmd  = cmd;
    case (state)
      ST_IDLE: begin
        if (!cmd_status.empty && cmd.cls == CLS_DIRECT && !res_status.full) begin
          cmd_pop  = 1'b1;
          res_push = 1'b1;
        end
      end
      ST_DONE: begin
        res_cmd.cls = CLS_DIRECT;
        if (ovf) begin
          res_cmd.res = '{kind: KIND_UNBOUNDED, lo: VAL_ZERO, hi: VAL_ZERO};
        end else begin
          res_cmd.res = '{kind: KIND_BOUNDED, lo: acc_lo, hi: acc_hi};
        end
        if (!res_status.full) begin
          cmd_pop  = 1'b1;
          res_push = 1'b1;
        end
      end
      default: begin
        cmd_pop  = 1'b0;
        res_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pval  <= 1'b0;
    end else begin
      state <= state_next;
      pval  <= (state == ST_MUL);
    end
  end

  always_ff @(posedge clk) begin
    pidx <= idx;
    prod <= $signed(a_sel) * $signed(b_sel);
    case (state)
      ST_IDLE: begin
        idx <= 2'd0;
        ovf <= 1'b0;
      end
      ST_MUL: begin
        idx <= idx + 1'b1;
      end
      ST_DIV_LOAD: begin
        cnt <= '0;
        rem <= '0;
        if (is_udiv) begin
          dvd  <= a_sel;
          dvs  <= b_sel;
          qneg <= 1'b0;
        end else begin
          dvd  <= a_sel[W-1] ? (VAL_ZERO - a_sel) : a_sel;
          dvs  <= b_sel[W-1] ? (VAL_ZERO - b_sel) : b_sel;
          qneg <= a_sel[W-1] ^ b_sel[W-1];
        end
      end
      ST_DIV_RUN: begin
        cnt <= cnt + 1'b1;
        if (!trial[W]) begin
          rem <= trial[W-1:0];
          dvd <= {dvd[W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[W-1:0];
          dvd <= {dvd[W-2:0], 1'b0};
        end
      end
      ST_DIV_FIN: begin
        idx <= idx + 1'b1;
        if (is_udiv) begin
          if (idx == 2'd0) begin
            acc_lo <= quot;
          end else begin
            acc_hi <= quot;
          end
        end else begin
          if (idx == 2'd0 || $signed(quot) < $signed(acc_lo)) begin
            acc_lo <= quot;
          end
          if (idx == 2'd0 || $signed(acc_hi) < $signed(quot)) begin
            acc_hi <= quot;
          end
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
    // hull of corner products as they leave the multiplier register
    if (pval) begin
      if (!pfits) begin
        ovf <= 1'b1;
      end
      if (pidx == 2'd0 || $signed(pv) < $signed(acc_lo)) begin
        acc_lo <= pv;
      end
      if (pidx == 2'd0 || $signed(acc_hi) < $signed(pv)) begin
        acc_hi <= pv;
      end
    end
  end

endmodule

/* rtl/interval_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// interval_arithmetic_unit
// Range arithmetic on pairs of signed intervals with queue-style ports.
// ----------------------------------------------------------------------------
// Items are taken at up to one per cycle, while the command queue is not full,
// into that four-entry queue; results leave in order through a four-entry
// result queue. Add, subtract, join, trivial and error cases are resolved on
// entry and retire one per cycle while the execution stage is idle and the
// result queue has room. A multiply holds the execution stage for four corner
// products through one registered 32x32 multiplier. Divides go through one
// radix-2 divider, one corner quotient at a time: four signed, two unsigned.
module interval_arithmetic_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic [2:0]                            operation,
  input  logic [1:0]                            kind_a,
  input  logic signed [iau_pkg::VALUE_WIDTH-1:0] low_a,
  input  logic signed [iau_pkg::VALUE_WIDTH-1:0] high_a,
  input  logic [1:0]                            kind_b,
  input  logic signed [iau_pkg::VALUE_WIDTH-1:0] low_b,
  input  logic signed [iau_pkg::VALUE_WIDTH-1:0] high_b,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [1:0]                            result_kind,
  output logic signed [iau_pkg::VALUE_WIDTH-1:0] result_low,
  output logic signed [iau_pkg::VALUE_WIDTH-1:0] result_high
);
  import iau_pkg::*;

  cmd_t      front_cmd;
  cmd_t      head_cmd;
  cmd_t      back_res;
  cmd_t      out_cmd;
  q_status_t cmd_status;
  q_status_t res_status;
  logic      cmd_pop;
  logic      res_push;

  iau_front u_front (
    .operation (operation),
    .kind_a    (kind_a),
    .low_a     (low_a),
    .high_a    (high_a),
    .kind_b    (kind_b),
    .low_b     (low_b),
    .high_b    (high_b),
    .cmd       (front_cmd)
  );

  iau_queue u_cmd_q (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (front_cmd),
    .pop    (cmd_pop),
    .rdata  (head_cmd),
    .status (cmd_status)
  );

  iau_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (head_cmd),
    .cmd_status (cmd_status),
    .cmd_pop    (cmd_pop),
    .res_status (res_status),
    .res_push   (res_push),
    .res_cmd    (back_res)
  );

  iau_queue u_res_q (
    .clk    (clk),
    .rst    (rst),
    .push   (res_push),
    .wdata  (back_res),
    .pop    (pop),
    .rdata  (out_cmd),
    .status (res_status)
  );

  assign full        = cmd_status.full;
  assign empty       = res_status.empty;
  assign result_kind = out_cmd.res.kind;
  assign result_low  = out_cmd.res.lo;
  assign result_high = out_cmd.res.hi;

endmodule
